@@ rtl/core/blt_pkg.sv @@
// shared types and constants for the badge location tracker
package blt_pkg;

    // configuration reset values
    localparam logic [15:0] ROAM_RESET = 16'd5;
    localparam logic [15:0] LAST_RESET = 16'd120;

    // register indexes on the configuration port
    localparam logic CFG_ROAM = 1'b0;
    localparam logic CFG_LAST = 1'b1;

    // request kinds
    localparam logic REQ_SIGHT = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status STAT_UPDATED = 3'd0;
    localparam t_status STAT_NEW     = 3'd1;
    localparam t_status STAT_DROPPED = 3'd2;
    localparam t_status STAT_HIT     = 3'd3;
    localparam t_status STAT_MISS    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_AGE_RD,
        S_AGE_LD,
        S_PLACE,
        S_PLACE_WR,
        S_SORT_P,
        S_AGE,
        S_SORT_A,
        S_WR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic rd;
        logic chk;
        logic idx_inc;
        logic idx_clr;
        logic load_row;
        logic place_step;
        logic place_wr;
        logic sort_start;
        logic sort_step;
        logic age;
        logic wr;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic scan_match;
        logic idx_last;
        logic is_target;
        logic row_occ;
        logic place_last;
        logic sort_fin;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/blt_ctrl.sv @@
// sequencing state machine of the badge location tracker
module blt_ctrl
    import blt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) n_state = S_SCAN_RD;
            end
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_sts.scan_match || i_sts.idx_last) begin
                    n_state = i_sts.is_query ? S_DONE : S_AGE_RD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_AGE_RD:   n_state = S_AGE_LD;
            S_AGE_LD: begin
                if (i_sts.is_target) n_state = S_PLACE;
                else if (i_sts.row_occ) n_state = S_AGE;
                else if (i_sts.idx_last) n_state = S_DONE;
                else n_state = S_AGE_RD;
            end
            S_PLACE: begin
                if (i_sts.place_last) n_state = S_PLACE_WR;
            end
            S_PLACE_WR: n_state = S_SORT_P;
            S_SORT_P: begin
                if (i_sts.sort_fin) n_state = S_AGE;
            end
            S_AGE:      n_state = S_SORT_A;
            S_SORT_A: begin
                if (i_sts.sort_fin) n_state = S_WR;
            end
            S_WR:       n_state = i_sts.idx_last ? S_DONE : S_AGE_RD;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready      = 1'b1;
                o_cmd.load_req = i_s_valid;
            end
            S_SCAN_RD:  o_cmd.rd = 1'b1;
            S_SCAN_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.scan_match || i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_AGE_RD:   o_cmd.rd = 1'b1;
            S_AGE_LD: begin
                o_cmd.load_row = 1'b1;
                o_cmd.idx_inc  = !i_sts.is_target && !i_sts.row_occ && !i_sts.idx_last;
            end
            S_PLACE:    o_cmd.place_step = 1'b1;
            S_PLACE_WR: begin
                o_cmd.place_wr   = 1'b1;
                o_cmd.sort_start = 1'b1;
            end
            S_SORT_P:   o_cmd.sort_step = 1'b1;
            S_AGE: begin
                o_cmd.age        = 1'b1;
                o_cmd.sort_start = 1'b1;
            end
            S_SORT_A:   o_cmd.sort_step = 1'b1;
            S_WR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.idx_inc = !i_sts.idx_last;
            end
            S_DONE:     o_cmd.out_load = i_sts.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/blt_dp.sv @@
// row memory, row register, place, sort and aging datapath
module blt_dp
    import blt_pkg::*;
#(
    parameter int BADGE_SLOTS    = 16,
    parameter int LOCS_PER_BADGE = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_req_type,
    input  logic [15:0] i_badge_id,
    input  logic [15:0] i_location_id,
    input  logic [31:0] i_now_seconds,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_m_ready,
    output logic        o_m_valid,
    output t_status     o_status,
    output logic [15:0] o_recent_location,
    output logic [15:0] o_second_location,
    output logic [15:0] o_third_location
);

    localparam int L  = LOCS_PER_BADGE;
    localparam int SW = (BADGE_SLOTS > 1) ? $clog2(BADGE_SLOTS) : 1;
    localparam int LW = (L > 1) ? $clog2(L) : 1;
    localparam int RW = 16 + L * 48;

    function automatic logic is_newer(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    // row memory: one badge slot per word
    logic [RW-1:0]          r_mem [BADGE_SLOTS];
    logic [BADGE_SLOTS-1:0] r_vld;
    logic [RW-1:0]          r_q;
    logic                   r_q_vld;

    // request and config
    logic        r_req_type;
    logic [15:0] r_req_badge;
    logic [15:0] r_req_loc;
    logic [31:0] r_req_now;
    logic [15:0] r_roam;
    logic [15:0] r_last;

    // scan results
    logic [SW-1:0] r_idx;
    logic          r_found;
    logic [SW-1:0] r_found_idx;
    logic          r_free;
    logic [SW-1:0] r_free_idx;

    // row register
    logic [15:0] r_badge;
    logic [15:0] r_loc [L];
    logic [31:0] r_tim [L];

    // place and sort counters
    logic [LW-1:0] r_pj;
    logic [LW-1:0] r_pick;
    logic [LW-1:0] r_si;
    logic [LW-1:0] r_sj;
    logic          r_need_key;
    logic [15:0]   r_key_loc;
    logic [31:0]   r_key_tim;

    // output register
    logic        r_o_valid;
    t_status     r_o_status;
    logic [15:0] r_o_loc [3];

    logic [15:0]   q_badge;
    logic [15:0]   q_loc [L];
    logic [31:0]   q_tim [L];
    logic [RW-1:0] w_word;
    logic          scan_match;
    logic          tgt_valid;
    logic [SW-1:0] tgt_idx;
    logic          is_target;
    logic          loc_hit;
    logic          pick_older;
    logic [LW-1:0] sj_m1;
    logic          shift_cond;
    logic          sort_fin;
    logic          clr [L];
    logic          out_free;
    t_status       status_c;

    // unpack read data, an unwritten row reads as zero
    always_comb begin
        q_badge = r_q_vld ? r_q[15:0] : 16'd0;
        for (int k = 0; k < L; k++) begin
            q_loc[k] = r_q_vld ? r_q[16 + 16 * k +: 16] : 16'd0;
            q_tim[k] = r_q_vld ? r_q[16 + 16 * L + 32 * k +: 32] : 32'd0;
        end
    end

    always_comb begin
        w_word        = '0;
        w_word[15:0]  = r_badge;
        for (int k = 0; k < L; k++) begin
            w_word[16 + 16 * k +: 16]          = r_loc[k];
            w_word[16 + 16 * L + 32 * k +: 32] = r_tim[k];
        end
    end

    assign scan_match = (r_req_badge != 16'd0) && (q_badge == r_req_badge);
    assign tgt_valid  = (r_req_badge != 16'd0) && (r_found || r_free);
    assign tgt_idx    = r_found ? r_found_idx : r_free_idx;
    assign is_target  = tgt_valid && (r_idx == tgt_idx);
    assign loc_hit    = (r_loc[r_pj] == r_req_loc);
    assign pick_older = is_newer(r_tim[r_pick], r_tim[r_pj]);
    assign sj_m1      = (r_sj == '0) ? '0 : r_sj - LW'(1);
    assign shift_cond = (r_sj != '0) && is_newer(r_key_tim, r_tim[sj_m1]);
    assign sort_fin   = (L == 1) ||
                        (!r_need_key && !shift_cond && (r_si == LW'(L - 1)));
    assign out_free   = !r_o_valid || i_m_ready;

    always_comb begin
        for (int k = 0; k < L; k++) begin
            logic [31:0] d;
            logic [15:0] lim;
            d      = r_req_now - r_tim[k];
            lim    = (k == 0) ? r_last : r_roam;
            clr[k] = (r_tim[k] != 32'd0) && !d[31] && (d > {16'd0, lim});
        end
    end

    always_comb begin
        if (r_req_type == REQ_QUERY) begin
            status_c = r_found ? STAT_HIT : STAT_MISS;
        end else if (!tgt_valid) begin
            status_c = STAT_DROPPED;
        end else begin
            status_c = r_found ? STAT_UPDATED : STAT_NEW;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.is_query   = (r_req_type == REQ_QUERY);
        o_sts.scan_match = scan_match;
        o_sts.idx_last   = (r_idx == SW'(BADGE_SLOTS - 1));
        o_sts.is_target  = is_target;
        o_sts.row_occ    = (q_badge != 16'd0);
        o_sts.place_last = loc_hit || (r_pj == LW'(L - 1));
        o_sts.sort_fin   = sort_fin;
        o_sts.out_free   = out_free;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_idx] <= w_word;
        end
        if (i_cmd.rd) begin
            r_q <= r_mem[r_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_q_vld     <= 1'b0;
            r_roam      <= ROAM_RESET;
            r_last      <= LAST_RESET;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_free      <= 1'b0;
            r_free_idx  <= '0;
            r_pj        <= '0;
            r_pick      <= '0;
            r_si        <= '0;
            r_sj        <= '0;
            r_need_key  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROAM: r_roam <= i_cfg_data;
                    CFG_LAST: r_last <= i_cfg_data;
                endcase
            end
            if (i_cmd.wr) r_vld[r_idx] <= 1'b1;
            if (i_cmd.rd) r_q_vld <= r_vld[r_idx];

            if (i_cmd.load_req || i_cmd.idx_clr) r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + SW'(1);

            if (i_cmd.load_req) begin
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (i_cmd.chk) begin
                if (scan_match) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_idx;
                end
                if ((q_badge == 16'd0) && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_idx;
                end
            end

            if (i_cmd.load_row) begin
                r_pj   <= '0;
                r_pick <= '0;
            end else if (i_cmd.place_step) begin
                if (loc_hit) r_pick <= r_pj;
                else if (pick_older) r_pick <= r_pj;
                if (r_pj != LW'(L - 1)) r_pj <= r_pj + LW'(1);
            end

            if (i_cmd.sort_start) begin
                r_si       <= LW'(1);
                r_sj       <= LW'(1);
                r_need_key <= 1'b1;
            end else if (i_cmd.sort_step && (L > 1)) begin
                if (r_need_key) begin
                    r_need_key <= 1'b0;
                end else if (shift_cond) begin
                    r_sj <= r_sj - LW'(1);
                end else if (r_si != LW'(L - 1)) begin
                    r_si       <= r_si + LW'(1);
                    r_sj       <= r_si + LW'(1);
                    r_need_key <= 1'b1;
                end
            end

            if (i_cmd.out_load) r_o_valid <= 1'b1;
            else if (i_m_ready) r_o_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type  <= i_req_type;
            r_req_badge <= i_badge_id;
            r_req_loc   <= i_location_id;
            r_req_now   <= i_now_seconds;
        end

        if ((i_cmd.chk && scan_match) || i_cmd.load_row) begin
            if (i_cmd.load_row && is_target && !r_found) r_badge <= r_req_badge;
            else r_badge <= q_badge;
            for (int k = 0; k < L; k++) begin
                r_loc[k] <= q_loc[k];
                r_tim[k] <= q_tim[k];
            end
        end else if (i_cmd.place_wr) begin
            r_loc[r_pick] <= r_req_loc;
            r_tim[r_pick] <= r_req_now;
        end else if (i_cmd.age) begin
            for (int k = 0; k < L; k++) begin
                if (clr[k]) begin
                    r_loc[k] <= 16'd0;
                    r_tim[k] <= 32'd0;
                end
            end
        end else if (i_cmd.sort_step && (L > 1)) begin
            if (r_need_key) begin
                r_key_loc <= r_loc[r_si];
                r_key_tim <= r_tim[r_si];
            end else if (shift_cond) begin
                r_loc[r_sj] <= r_loc[sj_m1];
                r_tim[r_sj] <= r_tim[sj_m1];
            end else begin
                r_loc[r_sj] <= r_key_loc;
                r_tim[r_sj] <= r_key_tim;
            end
        end

        if (i_cmd.out_load) begin
            r_o_status <= status_c;
            for (int k = 0; k < 3; k++) begin
                r_o_loc[k] <= 16'd0;
                if ((k < L) && (r_req_type == REQ_QUERY) && r_found) begin
                    r_o_loc[k] <= r_loc[k];
                end
            end
        end
    end

    assign o_m_valid         = r_o_valid;
    assign o_status          = r_o_status;
    assign o_recent_location = r_o_loc[0];
    assign o_second_location = r_o_loc[1];
    assign o_third_location  = r_o_loc[2];

endmodule

@@ rtl/core/badge_location_tracker_unit.sv @@
// top level of the badge location tracker
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tuser req_type, tdata badge/location/time
//  m_axis    out  m_axis_tvalid/tready        tuser status, tdata three locations
//  cfg       in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  one request is worked at a time; s_axis_tready is high only while the
//  controller is idle
//  a lookup reads the row memory one slot at a time and stops at the badge;
//  a query ends there and delivers its result
//  a sighting then sweeps every slot: a free slot is read and passed over,
//  an occupied one is aged, sorted and written back, and the updated slot
//  is first placed and sorted as well; a sort is an insertion sort, newest first
//  a sighting's length is set by the single port row memory and the one
//  compare per cycle sort
//  reset is synchronous active low; valid bits mark unwritten rows as empty,
//  so no clearing pass is needed
//  the result sits in an output register and holds while m_axis_tready is low
module badge_location_tracker_unit
    import blt_pkg::*;
#(
    parameter int BADGE_SLOTS    = 16,
    parameter int LOCS_PER_BADGE = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // badge_id, location_id, now_seconds
    input  logic        s_axis_tuser,   // req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // recent, second, third location
    output logic [2:0]  m_axis_tuser    // status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: scan, place, sort, age, write back, deliver
    blt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // row memory and per-row arithmetic
    blt_dp #(
        .BADGE_SLOTS    (BADGE_SLOTS),
        .LOCS_PER_BADGE (LOCS_PER_BADGE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (s_axis_tuser),
        .i_badge_id        (s_axis_tdata[15:0]),
        .i_location_id     (s_axis_tdata[31:16]),
        .i_now_seconds     (s_axis_tdata[63:32]),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_m_ready         (m_axis_tready),
        .o_m_valid         (m_axis_tvalid),
        .o_status          (m_axis_tuser),
        .o_recent_location (m_axis_tdata[15:0]),
        .o_second_location (m_axis_tdata[31:16]),
        .o_third_location  (m_axis_tdata[47:32])
    );

endmodule

@@ rtl/core/blt_checker.sv @@
// port level checks for the badge location tracker, bound to the top level
module blt_checker
    import blt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result beat changed while stalled");

    // one request at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    // status is a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= STAT_MISS))
        else $error("undefined status code");

    // locations only on a query hit
    a_locs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_HIT)) |-> (m_axis_tdata == 48'd0))
        else $error("locations reported without a query hit");

endmodule

bind badge_location_tracker_unit blt_checker u_blt_checker (.*);
